>>> sv/smsd_pkg.sv
// shared types, constants and helper functions for the sensor matrix scanner
package smsd_pkg;

    // matrix geometry
    localparam int MUX_COUNT     = 4;
    localparam int STEPS_PER_MUX = 16;
    localparam int STEP_W        = 4;
    localparam int MUX_W         = 2;
    localparam int CELL_COUNT    = 64;
    localparam int CELL_W        = 6;
    localparam int CELL_LAST     = 63;
    localparam int GROUP_W       = 8;
    localparam int GROUP_COUNT   = 8;

    // debounce settings
    localparam int          COUNT_W         = 8;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
    localparam logic [7:0]  COUNT_MAX       = 8'hFF;
    localparam logic [3:0]  LAST_STEP       = 4'(STEPS_PER_MUX - 1);
    localparam logic [63:0] BOARD_START     = 64'hFFFF_0000_0000_FFFF;

    typedef logic [MUX_COUNT-1:0]  sense_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [CELL_COUNT-1:0] board_t;
    typedef logic [CELL_W-1:0]     cell_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // scan stage to debounce stage
    typedef struct packed {
        board_t snapshot;
        logic   done;
        step_t  next_step;
    } scan_t;

    // one result item
    typedef struct packed {
        step_t  next_select;
        logic   scan_done;
        logic   change_accepted;
        cell_t  changed_square;
        logic   several_changed;
        board_t board_now;
    } result_t;

    // highest set bit: pick the top nonzero byte, then the top bit in it
    function automatic cell_t highest_set(input board_t v);
        logic [GROUP_COUNT-1:0] grp_any;
        logic [2:0]             grp;
        logic [GROUP_W-1:0]     grp_bits;
        logic [2:0]             pos;
        grp_any = '0;
        grp     = '0;
        pos     = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_any[g] = |v[g*GROUP_W +: GROUP_W];
        end
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            if (grp_any[g])
            begin
                grp = 3'(g);
            end
        end
        grp_bits = v[{grp, 3'b000} +: GROUP_W];
        for (int i = 0; i < GROUP_W; i++)
        begin
            if (grp_bits[i])
            begin
                pos = 3'(i);
            end
        end
        return {grp, pos};
    endfunction

endpackage

>>> sv/smsd_if.sv
// valid/ready channel interfaces for sense requests and scan results
interface smsd_in_if;
    logic              valid;
    logic              ready;
    smsd_pkg::sense_t  sense_bits;

    modport source (output valid, output sense_bits, input ready);
    modport sink   (input valid, input sense_bits, output ready);
endinterface

interface smsd_out_if;
    logic              valid;
    logic              ready;
    smsd_pkg::step_t   next_select;
    logic              scan_done;
    logic              change_accepted;
    smsd_pkg::cell_t   changed_square;
    logic              several_changed;
    smsd_pkg::board_t  board_now;

    modport source (output valid, output next_select, output scan_done,
                    output change_accepted, output changed_square,
                    output several_changed, output board_now, input ready);
    modport sink   (input valid, input next_select, input scan_done,
                    input change_accepted, input changed_square,
                    input several_changed, input board_now, output ready);
endinterface

>>> sv/smsd_scan.sv
// select step counter and snapshot assembly for one full matrix scan
module smsd_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  smsd_pkg::sense_t sense_bits,
    output smsd_pkg::scan_t  scan
);

    smsd_pkg::step_t  step_reg;
    smsd_pkg::step_t  step_next;
    smsd_pkg::board_t snap_reg;
    smsd_pkg::board_t snap_next;
    smsd_pkg::cell_t  cell_idx;
    logic             done;

    // place each sense bit at its cell, clear the rest at scan start
    always_comb
    begin
        snap_next = '0;
        cell_idx  = '0;
        for (int b = 0; b < smsd_pkg::CELL_COUNT; b++)
        begin
            cell_idx = smsd_pkg::CELL_W'(smsd_pkg::CELL_LAST - b);
            if (cell_idx[smsd_pkg::STEP_W-1:0] == step_reg)
            begin
                snap_next[b] = sense_bits[cell_idx[smsd_pkg::CELL_W-1:smsd_pkg::STEP_W]];
            end
            else if (step_reg == '0)
            begin
                snap_next[b] = 1'b0;
            end
            else
            begin
                snap_next[b] = snap_reg[b];
            end
        end
    end

    // step counter wraps after the last select code
    assign done      = (step_reg == smsd_pkg::LAST_STEP);
    assign step_next = done ? '0 : step_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (fire)
        begin
            step_reg <= step_next;
        end
    end

    // snapshot is payload, rebuilt from scratch at every scan start
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            snap_reg <= snap_next;
        end
    end

    assign scan.snapshot  = snap_next;
    assign scan.done      = done;
    assign scan.next_step = step_next;

    // a completed scan restarts the select sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> step_reg == '0)
        else $error("select step did not wrap after a full scan");

endmodule

>>> sv/smsd_debounce.sv
// board compare, debounce counter and change commit
module smsd_debounce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  smsd_pkg::count_t  threshold,
    input  smsd_pkg::scan_t   scan,
    output smsd_pkg::result_t result
);

    smsd_pkg::board_t board_reg;
    smsd_pkg::board_t board_next;
    smsd_pkg::count_t count_reg;
    smsd_pkg::count_t count_next;
    smsd_pkg::count_t count_up;
    smsd_pkg::cell_t  last_change_reg;
    smsd_pkg::cell_t  last_change_next;
    logic             last_several_reg;
    logic             last_several_next;
    smsd_pkg::board_t diff;
    logic             differs;
    logic             accepted;

    // difference against committed board
    assign diff     = board_reg ^ scan.snapshot;
    assign differs  = (diff != '0);
    assign count_up = (count_reg == smsd_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign accepted = scan.done && differs && (count_up >= threshold);

    // counter and commit
    always_comb
    begin
        board_next        = board_reg;
        count_next        = count_reg;
        last_change_next  = last_change_reg;
        last_several_next = last_several_reg;
        if (scan.done)
        begin
            if (accepted)
            begin
                board_next        = scan.snapshot;
                count_next        = '0;
                last_change_next  = smsd_pkg::highest_set(diff);
                last_several_next = ((diff & (diff - 1'b1)) != '0);
            end
            else if (differs)
            begin
                count_next = count_up;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg        <= smsd_pkg::BOARD_START;
            count_reg        <= '0;
            last_change_reg  <= '0;
            last_several_reg <= 1'b0;
        end
        else if (fire)
        begin
            board_reg        <= board_next;
            count_reg        <= count_next;
            last_change_reg  <= last_change_next;
            last_several_reg <= last_several_next;
        end
    end

    // result fields after this step
    assign result.next_select     = scan.next_step;
    assign result.scan_done       = scan.done;
    assign result.change_accepted = accepted;
    assign result.changed_square  = last_change_next;
    assign result.several_changed = last_several_next;
    assign result.board_now       = board_next;

    // a commit only happens at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> scan.done)
        else $error("board change committed mid scan");

    // a commit clears the debounce counter
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && accepted |=> count_reg == '0)
        else $error("debounce counter not cleared after commit");

    // the board only moves on a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !accepted |=> $stable(board_reg))
        else $error("board state changed without a commit");

endmodule

>>> sv/sensor_matrix_scan_debounce.sv
// top level of the sensor matrix scanner with debounce
//
//  channel   dir  handshake          payload
//  sense     in   valid/ready        sense_bits[3:0]
//  result    out  valid/ready        next_select, scan_done, change_accepted,
//                                    changed_square, several_changed, board_now
//  cfg       in   cfg_wr_en          cfg_wr_data[7:0] = stable_threshold
//
//  one request per cycle while the result side does not stall; a result is valid
//  once its request has passed the input register, then the result register
//  the end-of-scan compare and highest-bit encode sit in the result stage
//  reset puts the board at its start position and the threshold at 10
//  a stalled result holds the result register; one more request can wait in
//  the input register, after that ready drops
module sensor_matrix_scan_debounce (
    input  logic                     clk,
    input  logic                     rst_n,
    smsd_in_if.sink                  sense,
    smsd_out_if.source               result,
    input  logic                     cfg_wr_en,
    input  logic [7:0]               cfg_wr_data
);

    logic               in_valid_reg;
    smsd_pkg::sense_t   sense_reg;
    logic               res_valid_reg;
    smsd_pkg::result_t  res_reg;
    smsd_pkg::count_t   threshold_reg;
    smsd_pkg::scan_t    scan;
    smsd_pkg::result_t  res_next;
    logic               advance;
    logic               fire;
    logic               take;

    // handshake control
    assign advance     = !res_valid_reg || result.ready;
    assign fire        = in_valid_reg && advance;
    assign sense.ready = !in_valid_reg || advance;
    assign take        = sense.valid && sense.ready;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= smsd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sense_reg <= sense.sense_bits;
        end
    end

    smsd_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .sense_bits (sense_reg),
        .scan       (scan)
    );

    smsd_debounce u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .threshold  (threshold_reg),
        .scan       (scan),
        .result     (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.next_select     = res_reg.next_select;
    assign result.scan_done       = res_reg.scan_done;
    assign result.change_accepted = res_reg.change_accepted;
    assign result.changed_square  = res_reg.changed_square;
    assign result.several_changed = res_reg.several_changed;
    assign result.board_now       = res_reg.board_now;

endmodule

>>> dv/sensor_matrix_scan_debounce_tb.sv
// self-checking testbench for the sensor matrix scanner: scan requests in, results checked
module sensor_matrix_scan_debounce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    // tracks board, snapshot and debounce state and holds the expected results
    class scan_tracker;
        smsd_pkg::step_t   step_q;
        smsd_pkg::board_t  snap;
        smsd_pkg::board_t  board;
        smsd_pkg::count_t  count;
        smsd_pkg::cell_t   last_cell;
        logic              last_multi;
        logic [7:0]        threshold;
        smsd_pkg::result_t expected_q[$];
        int                errors;

        function new();
            step_q     = '0;
            snap       = '0;
            board      = smsd_pkg::BOARD_START;
            count      = '0;
            last_cell  = '0;
            last_multi = 1'b0;
            threshold  = smsd_pkg::THRESHOLD_RESET;
            errors     = 0;
        endfunction

        // index of the highest set cell bit, 0 when none
        function smsd_pkg::cell_t top_cell(input smsd_pkg::board_t v);
            smsd_pkg::cell_t pos;
            pos = '0;
            for (int i = 0; i < smsd_pkg::CELL_COUNT; i++)
            begin
                if (v[i])
                begin
                    pos = smsd_pkg::cell_t'(i);
                end
            end
            return pos;
        endfunction

        // advance the scan by one accepted request and queue its result
        function void note_request(input smsd_pkg::sense_t bits);
            smsd_pkg::step_t   cur;
            logic              done;
            logic              accepted;
            smsd_pkg::board_t  diff;
            int                p;
            smsd_pkg::result_t want;
            cur      = step_q;
            accepted = 1'b0;
            if (cur == '0)
            begin
                snap = '0;
            end
            for (int mux = 0; mux < smsd_pkg::MUX_COUNT; mux++)
            begin
                p = mux * smsd_pkg::STEPS_PER_MUX + int'(cur);
                snap[smsd_pkg::CELL_LAST - p] = bits[mux];
            end
            done = (cur == smsd_pkg::LAST_STEP);
            if (done)
            begin
                step_q = '0;
                if (snap != board)
                begin
                    if (count != smsd_pkg::COUNT_MAX)
                    begin
                        count = count + 1'b1;
                    end
                    if (count >= threshold)
                    begin
                        diff       = board ^ snap;
                        last_cell  = top_cell(diff);
                        last_multi = ((diff & (diff - 1'b1)) != '0);
                        board      = snap;
                        count      = '0;
                        accepted   = 1'b1;
                    end
                end
                else if (count != '0)
                begin
                    count = count - 1'b1;
                end
            end
            else
            begin
                step_q = cur + 1'b1;
            end
            want.next_select     = step_q;
            want.scan_done       = done;
            want.change_accepted = accepted;
            want.changed_square  = last_cell;
            want.several_changed = last_multi;
            want.board_now       = board;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            errors++;
            if (errors <= 40)
            begin
                $display("mismatch %s: got %h want %h", what, got, want);
            end
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(input smsd_pkg::result_t got);
            smsd_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got.next_select), '0);
                return;
            end
            want = expected_q.pop_front();
            if (got.next_select !== want.next_select)
                report_mismatch("next_select", 64'(got.next_select), 64'(want.next_select));
            if (got.scan_done !== want.scan_done)
                report_mismatch("scan_done", 64'(got.scan_done), 64'(want.scan_done));
            if (got.change_accepted !== want.change_accepted)
                report_mismatch("change_accepted", 64'(got.change_accepted),
                                64'(want.change_accepted));
            if (got.changed_square !== want.changed_square)
                report_mismatch("changed_square", 64'(got.changed_square),
                                64'(want.changed_square));
            if (got.several_changed !== want.several_changed)
                report_mismatch("several_changed", 64'(got.several_changed),
                                64'(want.several_changed));
            if (got.board_now !== want.board_now)
                report_mismatch("board_now", got.board_now, want.board_now);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    smsd_in_if  sense_ch();
    smsd_out_if result_ch();

    scan_tracker sb;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int cycles;

    sensor_matrix_scan_debounce u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sense       (sense_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side ready: random stalls plus long hold-offs on request
    initial
    begin
        result_ch.ready = 1'b0;
        hold_ack        = 0;
        hold_left       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        smsd_pkg::result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.next_select     = result_ch.next_select;
            got.scan_done       = result_ch.scan_done;
            got.change_accepted = result_ch.change_accepted;
            got.changed_square  = result_ch.changed_square;
            got.several_changed = result_ch.several_changed;
            got.board_now       = result_ch.board_now;
            sb.check_result(got);
        end
    end

    // sense bits that a board would give at one select step
    function automatic smsd_pkg::sense_t cells_at(input smsd_pkg::board_t brd,
                                                  input smsd_pkg::step_t s);
        smsd_pkg::sense_t v;
        for (int k = 0; k < smsd_pkg::MUX_COUNT; k++)
        begin
            v[k] = brd[smsd_pkg::CELL_LAST - (k * smsd_pkg::STEPS_PER_MUX + int'(s))];
        end
        return v;
    endfunction

    // offer one request, with random sender gaps, and wait for it to be taken
    task automatic send_request(input smsd_pkg::sense_t bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sense_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sense_ch.valid      <= 1'b1;
        sense_ch.sense_bits <= bits;
        do
            @(posedge clk);
        while (!sense_ch.ready);
        sb.note_request(bits);
    endtask

    // stop sending and wait until every expected result has come
    task automatic wait_results_done();
        sense_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_threshold(input logic [7:0] value);
        wait_results_done();
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        sb.threshold = value;
    endtask

    // random scans: mostly a target board repeated, plus matching, noise and cut scans
    task automatic run_scans(input int n, input int hold_at, input int pause_at);
        smsd_pkg::board_t target;
        smsd_pkg::board_t brd;
        int               reps_left;
        int               r;
        int               len;
        int               reps_max;
        target    = sb.board;
        reps_left = 0;
        for (int sc = 0; sc < n; sc++)
        begin
            if (sc == hold_at)
            begin
                hold_req <= hold_req + 1;
            end
            if (sc == pause_at)
            begin
                wait_results_done();
            end
            // pick a new target board when the last one has been repeated enough
            if (reps_left == 0)
            begin
                r = $urandom_range(99);
                if (r < 40)
                    target = sb.board ^ (64'd1 << $urandom_range(smsd_pkg::CELL_LAST));
                else if (r < 70)
                    target = sb.board ^ ({$urandom, $urandom} & {$urandom, $urandom});
                else
                    target = {$urandom, $urandom};
                reps_max  = (sb.threshold > 6) ? 6 : int'(sb.threshold) + 2;
                reps_left = $urandom_range(reps_max, 1);
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                brd = target;
                reps_left--;
            end
            else if (r < 85)
            begin
                brd = sb.board;
            end
            else
            begin
                brd = target ^ (64'd1 << $urandom_range(smsd_pkg::CELL_LAST));
            end
            len = ($urandom_range(99) < 5) ? $urandom_range(15, 1) : smsd_pkg::STEPS_PER_MUX;
            for (int i = 0; i < len; i++)
            begin
                send_request(cells_at(brd, sb.step_q));
            end
        end
    endtask

    // main sequence
    initial
    begin
        sense_ch.valid      = 1'b0;
        sense_ch.sense_bits = '0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        hold_req            = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        sb                  = new();
        rst_n               = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full occupied scan at the reset threshold, then edge patterns
        send_idle_pct = 26;
        recv_idle_pct = 52;
        for (int i = 0; i < smsd_pkg::STEPS_PER_MUX; i++)
        begin
            send_request(4'hF);
        end
        send_request(4'h0);
        send_request(4'h1);
        send_request(4'h2);
        send_request(4'h4);
        send_request(4'h8);
        send_request(4'hE);
        send_request(4'hD);
        send_request(4'hB);
        send_request(4'h7);

        // sender light gaps, receiver heavy stalls
        write_threshold(8'd1);
        run_scans(12, -1, -1);

        // swapped
        send_idle_pct = 52;
        recv_idle_pct = 26;
        write_threshold(8'd3);
        run_scans(12, -1, -1);

        // no idling, with a long receiver hold-off and a full drain mid-way
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(8'd2);
        run_scans(12, 3, 7);

        // threshold extremes
        write_threshold(8'd255);
        run_scans(3, -1, -1);
        write_threshold(8'd0);
        run_scans(3, -1, -1);

        wait_results_done();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/smsd_pkg.sv
sv/smsd_if.sv
sv/smsd_scan.sv
sv/smsd_debounce.sv
sv/sensor_matrix_scan_debounce.sv
dv/sensor_matrix_scan_debounce_tb.sv
